/* hdl/lhlw_pkg.sv */
package lhlw_pkg;

	localparam int unsigned MAX_CLASSES_DEF      = 32;
	localparam int unsigned COUNT_BITS_DEF       = 40;
	localparam int unsigned WEIGHT_FRAC_BITS_DEF = 16;

	localparam int unsigned NUM_CLASSES_W = 6;
	localparam logic [NUM_CLASSES_W-1:0] NUM_CLASSES_RST = 6'd19;

	localparam int unsigned LABEL_W  = 8;
	localparam int unsigned INDEX_W  = 5;
	localparam int unsigned WEIGHT_W = 22;

	// log2 / ln fixed point formats
	localparam int unsigned LN_FRAC   = 28;
	localparam int unsigned MANT_FRAC = 30;
	localparam int unsigned MANT_W    = MANT_FRAC + 2;
	localparam int unsigned LOG2_W    = 7 + LN_FRAC;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	// reciprocal 2^60 / ln stays below 2^33 (ln >= ln 2)
	localparam int unsigned RECIP_SHIFT = 60;
	localparam int unsigned RECIP_W     = 33;

	// input commands
	localparam logic CMD_COUNT  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

endpackage

/* hdl/lhlw_divider.sv */
// restoring divider, one quotient bit per cycle
module lhlw_divider #(
	parameter int unsigned NUM_W = 64,
	parameter int unsigned DEN_W = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_sub;

	// shift in the next numerator bit and try subtracting
	always_comb begin
		rem_sh  = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= numer;
			rem_q  <= '0;
			den_q  <= denom;
		end else if (run_q) begin
			if (!rem_sub[DEN_W]) begin
				rem_q  <= rem_sub;
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hdl/label_histogram_log_weights.sv */
// label histogram with inverse log frequency class weights
//
// start with command = count bumps the saturating count of class label; labels at
// or above the class count register (clamped to MAX_CLASSES) are dropped. busy stays
// low while counting, so one label is taken every cycle with no result; the memory
// read-modify-write is pipelined and back to back hits on one class are forwarded.
// start with command = finish raises busy: the count pipeline drains first, then a
// first pass over the classes skips a zero count and for a nonzero one runs 28
// squaring steps for ln(1+c), then the 88 bit serial divider for 2^60/ln, forming
// the reciprocal sum. A second pass runs one divide per nonzero class for the
// weight; each weight is strobed on res_valid in the cycle after its divide, in
// class order, with last on the final one. An empty histogram gives one result
// with empty_res set. Every finish ends with a clear pass over all MAX_CLASSES
// entries of the count memory; busy stays high throughout. The receiver cannot stall.
// Reset clears control state and runs the same clear pass, with busy high.
// cfg_valid/cfg_ready write the class count register; cfg_ready is high while idle.
module label_histogram_log_weights #(
	parameter int unsigned MAX_CLASSES      = lhlw_pkg::MAX_CLASSES_DEF,
	parameter int unsigned COUNT_BITS       = lhlw_pkg::COUNT_BITS_DEF,
	parameter int unsigned WEIGHT_FRAC_BITS = lhlw_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lhlw_pkg::NUM_CLASSES_W-1:0] cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [lhlw_pkg::LABEL_W-1:0]      label,
	output logic                              res_valid,
	output logic [lhlw_pkg::INDEX_W-1:0]      class_index,
	output logic [lhlw_pkg::WEIGHT_W-1:0]     weight,
	output logic                              empty_res,
	output logic                              saturated,
	output logic                              last
);

	localparam int unsigned AW     = $clog2(MAX_CLASSES);
	localparam int unsigned NW     = lhlw_pkg::NUM_CLASSES_W + 1;
	localparam int unsigned RW     = lhlw_pkg::RECIP_W;
	localparam int unsigned SW     = RW + AW + 1;
	localparam int unsigned DIV_W  = 64 + WEIGHT_FRAC_BITS + 8;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef enum logic [11:0] {
		ST_CLEAR  = 12'b000000000001,
		ST_IDLE   = 12'b000000000010,
		ST_RD     = 12'b000000000100,
		ST_RDW    = 12'b000000001000,
		ST_LOGN   = 12'b000000010000,
		ST_LOGSQ  = 12'b000000100000,
		ST_LNMUL  = 12'b000001000000,
		ST_RDIV   = 12'b000010000000,
		ST_WNUM   = 12'b000100000000,
		ST_WDIV   = 12'b001000000000,
		ST_EMPTY  = 12'b010000000000,
		ST_NEXT   = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [lhlw_pkg::NUM_CLASSES_W-1:0] ncfg_q;
	logic [NW-1:0] neff;
	always_comb begin
		if (NW'(ncfg_q) > NW'(MAX_CLASSES)) neff = NW'(MAX_CLASSES);
		else neff = NW'(ncfg_q);
	end

	assign cfg_ready = (state_q == ST_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ncfg_q <= lhlw_pkg::NUM_CLASSES_RST;
		else if (cfg_valid && cfg_ready) ncfg_q <= cfg_data;
	end

	logic [AW-1:0] idx_q;
	logic [NW-1:0] pass_q;  // 0 = recip pass, 1 = weight pass
	logic [AW-1:0] clr_q;
	logic [AW-1:0] lastnz_q;

	// count memory and the recip store
	logic [COUNT_BITS-1:0] cnt_mem [MAX_CLASSES];
	logic [RW-1:0]         rcp_mem [MAX_CLASSES];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [RW-1:0]         rcp_rd_q;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  rcp_we;
	logic [RW-1:0]         rcp_wd;

	always_ff @(posedge clk) begin
		if (wr_en) cnt_mem[wr_addr] <= wr_data;
		cnt_rd_q <= cnt_mem[rd_addr];
	end
	always_ff @(posedge clk) begin
		if (rcp_we) rcp_mem[idx_q] <= rcp_wd;
		rcp_rd_q <= rcp_mem[rd_addr];
	end

	// count pipeline: read issued on accept, s1 modify and write, s2 holds the written count for forwarding
	logic              hit_s1;
	logic [AW-1:0]     lab_s1;
	logic              hit_s2;
	logic [AW-1:0]     lab_s2;
	logic [COUNT_BITS-1:0] newc_s2;
	logic [COUNT_BITS-1:0] oldc;
	logic [COUNT_BITS-1:0] newc;
	logic              ovf_q;
	logic              acc_cnt;

	assign busy    = (state_q != ST_IDLE);
	assign acc_cnt = start && !busy && (command == lhlw_pkg::CMD_COUNT)
		&& ({1'b0, label} < (lhlw_pkg::LABEL_W+1)'(neff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
			hit_s2 <= 1'b0;
		end else begin
			hit_s1 <= acc_cnt;
			hit_s2 <= hit_s1;
		end
	end
	always_ff @(posedge clk) begin
		lab_s1  <= AW'(label);
		lab_s2  <= lab_s1;
		newc_s2 <= newc;
	end

	// forward the previous write when it hits the same class
	always_comb begin
		if (hit_s2 && lab_s2 == lab_s1) oldc = newc_s2;
		else oldc = cnt_rd_q;
		newc = (oldc == CMAX) ? oldc : oldc + 1'b1;
	end

	// log datapath
	logic [6:0]                      exp_q;
	logic [lhlw_pkg::MANT_W-1:0]     mant_q;
	logic [lhlw_pkg::LN_FRAC-1:0]    frac_q;
	logic [4:0]                      step_q;
	logic [2*lhlw_pkg::MANT_W-1:0]   sq;
	logic [lhlw_pkg::MANT_W-1:0]     sqt;
	logic [64:0]                     xval;
	logic [6:0]                      msb;
	logic [lhlw_pkg::LOG2_W+29:0]    lnprod;

	assign xval = 65'(cnt_rd_q) + 65'd1;
	always_comb begin
		msb = '0;
		for (int b = 0; b < 65; b++) if (xval[b]) msb = 7'(b);
	end
	assign sq     = mant_q * mant_q;
	assign sqt    = lhlw_pkg::MANT_W'(sq >> lhlw_pkg::MANT_FRAC);
	assign lnprod = {exp_q, frac_q} * lhlw_pkg::LN2_Q30;

	// shared divider
	logic             dv_start;
	logic [DIV_W-1:0] dv_num;
	logic [SW-1:0]    dv_den;
	logic             dv_done;
	logic [DIV_W-1:0] dv_quot;

	lhlw_divider #(.NUM_W(DIV_W), .DEN_W(SW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dv_start),
		.numer (dv_num),
		.denom (dv_den),
		.done  (dv_done),
		.quot  (dv_quot)
	);

	logic [SW-1:0]    sum_q;
	logic [RW+NW-1:0] wprod;
	logic             any_q;
	logic             sat_q;

	// finish sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			pass_q   <= '0;
			lastnz_q <= '0;
			any_q    <= 1'b0;
			sat_q    <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (hit_s2 && newc_s2 == CMAX) ovf_q <= 1'b1;
			unique case (state_q)
				ST_CLEAR: begin
					if (32'(clr_q) == MAX_CLASSES - 1) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start && command == lhlw_pkg::CMD_FINISH) begin
						idx_q   <= '0;
						pass_q  <= '0;
						any_q   <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// wait for the count pipeline to drain on first entry
					if (!hit_s1 && !hit_s2) begin
						if (neff == '0) state_q <= ST_EMPTY;
						else state_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					sat_q <= ovf_q;
					if (pass_q == '0) begin
						if (cnt_rd_q == '0) state_q <= ST_NEXT;
						else state_q <= ST_LOGN;
					end else begin
						if (rcp_rd_q == '0) state_q <= ST_NEXT;
						else state_q <= ST_WNUM;
					end
				end
				ST_LOGN: begin
					step_q <= 5'(lhlw_pkg::LN_FRAC - 1);
					state_q <= ST_LOGSQ;
				end
				ST_LOGSQ: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= ST_LNMUL;
				end
				ST_LNMUL: begin
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (dv_done) begin
						any_q    <= 1'b1;
						lastnz_q <= idx_q;
						state_q  <= ST_NEXT;
					end
				end
				ST_WNUM: begin
					state_q <= ST_WDIV;
				end
				ST_WDIV: begin
					if (dv_done) begin
						res_valid <= 1'b1;
						state_q   <= ST_NEXT;
					end
				end
				ST_EMPTY: begin
					res_valid <= 1'b1;
					ovf_q     <= 1'b0;
					state_q   <= ST_CLEAR;
				end
				ST_NEXT: begin
					if (NW'(idx_q) == neff - 1'b1) begin
						idx_q <= '0;
						if (pass_q == '0) begin
							if (any_q) begin
								pass_q  <= NW'(1);
								state_q <= ST_RD;
							end else begin
								state_q <= ST_EMPTY;
							end
						end else begin
							ovf_q   <= 1'b0;
							state_q <= ST_CLEAR;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of the finish run
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: sum_q <= '0;
			ST_LOGN: begin
				exp_q <= msb;
				if (msb >= 7'(lhlw_pkg::MANT_FRAC))
					mant_q <= lhlw_pkg::MANT_W'(xval >> (msb - 7'(lhlw_pkg::MANT_FRAC)));
				else
					mant_q <= lhlw_pkg::MANT_W'(xval << (7'(lhlw_pkg::MANT_FRAC) - msb));
				frac_q <= '0;
			end
			ST_LOGSQ: begin
				if (sqt[lhlw_pkg::MANT_W-1]) begin
					mant_q <= sqt >> 1;
					frac_q[step_q] <= 1'b1;
				end else begin
					mant_q <= sqt;
				end
			end
			ST_RDIV: if (dv_done) sum_q <= sum_q + SW'(dv_quot);
			ST_WDIV: if (dv_done) begin
				class_index <= lhlw_pkg::INDEX_W'(idx_q);
				weight      <= lhlw_pkg::WEIGHT_W'(dv_quot);
				empty_res   <= 1'b0;
				saturated   <= sat_q;
				// last on the highest nonzero class
				last        <= (idx_q == lastnz_q);
			end
			ST_EMPTY: begin
				class_index <= '0;
				weight      <= '0;
				empty_res   <= 1'b1;
				saturated   <= ovf_q;
				last        <= 1'b1;
			end
			default: ;
		endcase
	end

	// divider hookup
	assign wprod = (RW+NW)'(neff) * (RW+NW)'(rcp_rd_q);
	always_comb begin
		dv_start = (state_q == ST_LNMUL) || (state_q == ST_WNUM);
		dv_num   = (DIV_W'(1) << lhlw_pkg::RECIP_SHIFT);
		dv_den   = SW'(lnprod >> 30);
		if (state_q == ST_WNUM) begin
			dv_num = DIV_W'({wprod, {WEIGHT_FRAC_BITS{1'b0}}}) + DIV_W'(sum_q >> 1);
			dv_den = sum_q;
		end
	end

	// recip store write and count clearing
	assign rcp_we = (state_q == ST_RDIV && dv_done) || (state_q == ST_RDW && pass_q == '0)
		|| state_q == ST_CLEAR;
	assign rcp_wd = (state_q == ST_RDIV) ? RW'(dv_quot) : '0;

	always_comb begin
		rd_addr = acc_cnt ? AW'(label) : idx_q;
		wr_en   = hit_s1;
		wr_addr = lab_s1;
		wr_data = newc;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1; wr_addr = clr_q; wr_data = '0;
		end else if (state_q == ST_RDW && pass_q == '0) begin
			wr_en = 1'b1; wr_addr = idx_q; wr_data = '0;
		end
	end

endmodule

/* dv/label_histogram_log_weights_tb.sv */
`timescale 1ns / 100ps

module label_histogram_log_weights_tb;

	localparam int unsigned MAXC       = lhlw_pkg::MAX_CLASSES_DEF;
	localparam int unsigned CBITS      = lhlw_pkg::COUNT_BITS_DEF;
	localparam int unsigned WFRAC      = lhlw_pkg::WEIGHT_FRAC_BITS_DEF;
	localparam longint unsigned CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [lhlw_pkg::INDEX_W-1:0]  class_index;
		logic [lhlw_pkg::WEIGHT_W-1:0] weight;
		logic                          empty_res;
		logic                          saturated;
		logic                          last;
	} class_weight_t;

	// histogram predictor and the queue of weights it has promised
	class weight_scoreboard;
		logic [CBITS-1:0] hist [MAXC];
		logic             overflow;
		logic [lhlw_pkg::NUM_CLASSES_W-1:0] classes_reg;
		class_weight_t    pending [$];
		int unsigned      mismatches;
		int unsigned      finishes;
		int unsigned      results_seen;

		function new();
			foreach (hist[i]) hist[i] = '0;
			overflow     = 1'b0;
			classes_reg  = lhlw_pkg::NUM_CLASSES_RST;
			mismatches   = 0;
			finishes     = 0;
			results_seen = 0;
		endfunction

		function int unsigned eff_classes();
			return (classes_reg > MAXC) ? MAXC : classes_reg;
		endfunction

		function void set_classes(logic [lhlw_pkg::NUM_CLASSES_W-1:0] v);
			classes_reg = v;
		endfunction

		// ln(1+c) in Q.28 by repeated squaring of the mantissa
		function longint unsigned ln1p_q28(longint unsigned c);
			longint unsigned x, m, frac, log2v;
			int e;
			x = c + 1;
			e = 63;
			frac = 0;
			while (((x >> e) & 1) == 0) e--;
			if (e >= lhlw_pkg::MANT_FRAC) m = x >> (e - lhlw_pkg::MANT_FRAC);
			else m = x << (lhlw_pkg::MANT_FRAC - e);
			for (int k = lhlw_pkg::LN_FRAC - 1; k >= 0; k--) begin
				m = (m * m) >> lhlw_pkg::MANT_FRAC;
				if (m >= (64'd2 << lhlw_pkg::MANT_FRAC)) begin
					m = m >> 1;
					frac = frac | (64'd1 << k);
				end
			end
			log2v = (longint'(e) << lhlw_pkg::LN_FRAC) | frac;
			return (log2v * 64'(lhlw_pkg::LN2_Q30)) >> 30;
		endfunction

		// accepted input transfer
		function void note(logic cmd, logic [lhlw_pkg::LABEL_W-1:0] lab);
			int unsigned n;
			longint unsigned recip [MAXC];
			longint unsigned total, num;
			class_weight_t r;
			n = eff_classes();
			total = 0;
			if (cmd == lhlw_pkg::CMD_COUNT) begin
				if (lab < n) begin
					if (hist[lab] != {CBITS{1'b1}}) hist[lab] = hist[lab] + 1'b1;
					if (hist[lab] == {CBITS{1'b1}}) overflow = 1'b1;
				end
				return;
			end
			finishes++;
			for (int i = 0; i < n; i++) begin
				recip[i] = 0;
				if (hist[i] != 0) begin
					recip[i] = (64'd1 << lhlw_pkg::RECIP_SHIFT) / ln1p_q28(64'(hist[i]));
					total += recip[i];
				end
			end
			if (total == 0) begin
				r.class_index = '0;
				r.weight      = '0;
				r.empty_res   = 1'b1;
				r.saturated   = overflow;
				r.last        = 1'b1;
				pending.insert(pending.size(), r);
			end else begin
				for (int i = 0; i < n; i++) begin
					if (hist[i] != 0) begin
						num = ((64'(n) * recip[i]) << WFRAC) + total / 2;
						r.class_index = i[lhlw_pkg::INDEX_W-1:0];
						r.weight      = lhlw_pkg::WEIGHT_W'(num / total);
						r.empty_res   = 1'b0;
						r.saturated   = overflow;
						r.last        = 1'b0;
						pending.insert(pending.size(), r);
					end
				end
				pending[pending.size()-1].last = 1'b1;
			end
			foreach (hist[i]) hist[i] = '0;
			overflow = 1'b0;
		endfunction

		// one result transfer against the oldest prediction
		function void check(class_weight_t got);
			class_weight_t exp_r;
			longint diff;
			bit bad;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: class %0d weight %0d", got.class_index,
						got.weight);
				return;
			end
			exp_r = pending.pop_front();
			diff = longint'(got.weight) - longint'(exp_r.weight);
			// weights may differ by one lsb
			bad = (got.class_index !== exp_r.class_index) || (diff > 1) || (diff < -1) ||
				(got.empty_res !== exp_r.empty_res) || (got.saturated !== exp_r.saturated) ||
				(got.last !== exp_r.last) || $isunknown(got.weight);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp idx %0d w %0d e %0b s %0b l %0b",
						exp_r.class_index, exp_r.weight, exp_r.empty_res, exp_r.saturated,
						exp_r.last, " / got idx %0d w %0d e %0b s %0b l %0b",
						got.class_index, got.weight, got.empty_res, got.saturated, got.last);
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [lhlw_pkg::NUM_CLASSES_W-1:0] cfg_data;
	logic                               start;
	logic                               busy;
	logic                               command;
	logic [lhlw_pkg::LABEL_W-1:0]       label;
	logic                               res_valid;
	logic [lhlw_pkg::INDEX_W-1:0]       class_index;
	logic [lhlw_pkg::WEIGHT_W-1:0]      weight;
	logic                               empty_res;
	logic                               saturated;
	logic                               last;

	weight_scoreboard sb;
	int unsigned      burst_left;
	longint unsigned  cycles;

	label_histogram_log_weights i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.label       (label),
		.res_valid   (res_valid),
		.class_index (class_index),
		.weight      (weight),
		.empty_res   (empty_res),
		.saturated   (saturated),
		.last        (last)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// result monitor, receiver cannot stall
	always @(posedge clk) begin
		class_weight_t got;
		if (arst_n && res_valid) begin
			got.class_index = class_index;
			got.weight      = weight;
			got.empty_res   = empty_res;
			got.saturated   = saturated;
			got.last        = last;
			sb.check(got);
		end
	end

	// one input transfer, then maybe a gap between bursts
	task automatic send(logic cmd, logic [lhlw_pkg::LABEL_W-1:0] lab);
		start   <= 1'b1;
		command <= cmd;
		label   <= lab;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note(cmd, lab);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	// wait for every predicted weight, then let the block settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	// register transfer, only while idle
	task automatic write_classes(logic [lhlw_pkg::NUM_CLASSES_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_classes(v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly in-range labels, some out of range, some full-byte noise, with finishes mixed in
	task automatic random_phase(logic [lhlw_pkg::NUM_CLASSES_W-1:0] v, int unsigned items);
		int unsigned n;
		int unsigned sel;
		write_classes(v);
		n = (v > MAXC) ? MAXC : v;
		for (int i = 0; i < items; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 7) send(lhlw_pkg::CMD_FINISH, 8'($urandom));
			else if (sel < 80 && n > 0) begin
				// skew towards low classes so counts differ widely
				if ($urandom_range(0, 1))
					send(lhlw_pkg::CMD_COUNT, 8'($urandom_range(0, (n + 3) / 4 - 1)));
				else send(lhlw_pkg::CMD_COUNT, 8'($urandom_range(0, n - 1)));
			end else if (sel < 90) send(lhlw_pkg::CMD_COUNT, 8'($urandom_range(n, 255)));
			else send(lhlw_pkg::CMD_COUNT, 8'($urandom));
		end
		send(lhlw_pkg::CMD_FINISH, 8'($urandom));
		drain();
	endtask

	initial begin
		sb         = new();
		burst_left = 0;
		cycles     = 0;
		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		start      = 1'b0;
		command    = lhlw_pkg::CMD_COUNT;
		label      = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset setting, empty finish, edges of the label range
		send(lhlw_pkg::CMD_FINISH, 8'h00);
		send(lhlw_pkg::CMD_COUNT, 8'd0);
		send(lhlw_pkg::CMD_COUNT, 8'd18);
		send(lhlw_pkg::CMD_COUNT, 8'd19);
		send(lhlw_pkg::CMD_COUNT, 8'd255);
		send(lhlw_pkg::CMD_COUNT, 8'd0);
		send(lhlw_pkg::CMD_FINISH, 8'hff);
		drain();
		// single class
		write_classes(6'd1);
		send(lhlw_pkg::CMD_COUNT, 8'd0);
		send(lhlw_pkg::CMD_COUNT, 8'd1);
		send(lhlw_pkg::CMD_FINISH, 8'h55);
		drain();
		// zero classes counts nothing
		write_classes(6'd0);
		send(lhlw_pkg::CMD_COUNT, 8'd0);
		send(lhlw_pkg::CMD_COUNT, 8'd170);
		send(lhlw_pkg::CMD_FINISH, 8'h00);
		drain();
		// full width, then above the maximum is clamped
		write_classes(6'd32);
		send(lhlw_pkg::CMD_COUNT, 8'd31);
		send(lhlw_pkg::CMD_COUNT, 8'd32);
		send(lhlw_pkg::CMD_COUNT, 8'd5);
		send(lhlw_pkg::CMD_FINISH, 8'h00);
		drain();
		write_classes(6'd63);
		send(lhlw_pkg::CMD_COUNT, 8'd31);
		send(lhlw_pkg::CMD_COUNT, 8'd63);
		send(lhlw_pkg::CMD_COUNT, 8'd0);
		send(lhlw_pkg::CMD_FINISH, 8'h00);
		drain();

		// random phases over several settings
		random_phase(6'd32, 30);
		random_phase(6'd1, 20);
		random_phase(6'd63, 30);
		random_phase(6'd0, 15);
		for (int p = 0; p < 6; p++) random_phase(6'($urandom_range(1, 63)), 20);
		random_phase(6'd19, 20);

		$display("%0d finishes and %0d weight transfers checked over class counts 0 to 63",
			sb.finishes, sb.results_seen);
		$display("%0d mismatches found", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
